>>> rtl/prat_pkg.sv
// Shared types and codes for the page range address translator.
// Used by the core; depends on nothing else.
`timescale 1ns / 1ps

package prat_pkg;

    localparam int ADDR_W   = 31;
    localparam int SIZE_W   = 31;
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 30;
    localparam int TAG_W    = 32;
    localparam int STATUS_W = 3;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 80;

    localparam logic [ADDR_W-1:0] ADDR_MAX   = 31'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 31'h4000_0000;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ENCODE = 2'd1,
        OP_DECODE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NOT_FOUND  = 3'd1,
        STAT_BAD_INDEX  = 3'd2,
        STAT_MISALIGNED = 3'd3,
        STAT_FULL       = 3'd4,
        STAT_OVERFLOW   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK
    } state_t;

    typedef struct packed {
        status_t              status;
        logic [TAG_W-1:0]     encoded_address;
        logic [INDEX_W-1:0]   found_index;
        logic [OFFSET_W-1:0]  found_offset;
    } result_t;

endpackage

>>> rtl/prat_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the page range table; no package dependency.
`timescale 1ns / 1ps

module prat_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 256
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/page_range_address_translator_core.sv
// Page range address translator core.
// One request enters on the s_ stream and gives exactly one result on the m_ stream.
// Op append places a page at the running offset, op encode turns a page index and
// byte offset into a marked word address, op decode finds the page holding an address.
// Timing: append, rejected requests and decodes that are unmarked or find the table
// empty give their result on the cycle after acceptance. Encode passes through the
// read and check states (one table read). Decode runs a binary search over the
// stored ranges, one read and check state pair per table read (address, compare).
// The table RAM read port sets this sequence. One request is worked on at a time.
// The result sits in an output register; while it waits for m_tready the next
// request is taken only if that register frees up in the same cycle.
// Reset (aresetn low, synchronous) empties the table by clearing the page count and
// running offset; table contents need no clearing since only written entries are read.
// Depends on prat_pkg and prat_ram.
`timescale 1ns / 1ps

module page_range_address_translator_core #(
    parameter int MAX_PAGES   = 256,
    parameter int GUARD_WORDS = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // tdata: op[1:0], page_size_bytes[32:2], page_index[40:33],
    //        byte_offset[70:41], tagged_address[102:71], zero pad[103]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [prat_pkg::S_TDATA_W-1:0]  s_tdata,
    // tdata: status[2:0], encoded_address[34:3], found_index[42:35],
    //        found_offset[72:43], zero pad[79:73]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prat_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW  = $clog2(MAX_PAGES + 1);
    localparam int AWD = prat_pkg::ADDR_W;
    localparam int RW  = 2 * AWD;

    // input fields
    logic [1:0]                     s_op;
    logic [prat_pkg::SIZE_W-1:0]    s_page_size_bytes;
    logic [prat_pkg::INDEX_W-1:0]   s_page_index;
    logic [prat_pkg::OFFSET_W-1:0]  s_byte_offset;
    logic [prat_pkg::TAG_W-1:0]     s_tagged_address;

    assign s_op              = s_tdata[1:0];
    assign s_page_size_bytes = s_tdata[32:2];
    assign s_page_index      = s_tdata[40:33];
    assign s_byte_offset     = s_tdata[70:41];
    assign s_tagged_address  = s_tdata[102:71];

    prat_pkg::state_t   state_reg, state_next;
    prat_pkg::op_t      op_reg, op_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AWD-1:0]     next_start_reg, next_start_next;
    logic [AWD-1:0]     addr_reg, addr_next;
    logic [27:0]        woff_reg, woff_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      best_idx_reg, best_idx_next;
    logic [AWD-1:0]     best_start_reg, best_start_next;
    logic [AWD-1:0]     best_end_reg, best_end_next;
    logic               best_found_reg, best_found_next;
    logic               m_valid_reg, m_valid_next;
    prat_pkg::result_t  m_res_reg, res;
    logic               res_load;

    // table RAM: {range_end, range_start}
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [RW-1:0]      ram_wdata, ram_rdata;
    logic [AWD-1:0]     rd_start, rd_end;

    logic               s_accept, out_free;
    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid_full;

    // append datapath
    logic [28:0]        app_words;
    logic [31:0]        app_end;
    logic [32:0]        app_nxt;

    // encode / decode datapath
    logic [31:0]        enc_addr;
    logic               le_hit;
    logic [CW-1:0]      lo_c, hi_c, bi_c;
    logic [AWD-1:0]     bs_c, be_c, dec_diff;
    logic               bf_c;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == prat_pkg::ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_full = mid_sum[CW:1];

    assign ram_raddr = (op_reg == prat_pkg::OP_DECODE) ? mid_full[AW-1:0] : idx_reg;
    assign rd_start  = ram_rdata[AWD-1:0];
    assign rd_end    = ram_rdata[RW-1:AWD];

    assign app_words = 29'((32'(s_page_size_bytes) + 32'd3) >> 2);
    assign app_end   = {1'b0, next_start_reg} + 32'(app_words);
    assign app_nxt   = {1'b0, app_end} + 33'(GUARD_WORDS);

    assign enc_addr  = {1'b0, rd_start} + {4'b0, woff_reg};

    assign le_hit   = (rd_start <= addr_reg);
    assign lo_c     = le_hit ? CW'(mid_full + 1'b1) : lo_reg;
    assign hi_c     = le_hit ? hi_reg : mid_full;
    assign bi_c     = le_hit ? mid_full : best_idx_reg;
    assign bs_c     = le_hit ? rd_start : best_start_reg;
    assign be_c     = le_hit ? rd_end : best_end_reg;
    assign bf_c     = le_hit || best_found_reg;
    assign dec_diff = addr_reg - bs_c;

    prat_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_PAGES)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        count_next      = count_reg;
        next_start_next = next_start_reg;
        addr_next       = addr_reg;
        woff_next       = woff_reg;
        idx_next        = idx_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        best_end_next   = best_end_reg;
        best_found_next = best_found_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        res             = '0;
        res.status      = prat_pkg::STAT_NOT_FOUND;
        res_load        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = count_reg[AW-1:0];
        ram_wdata       = {app_end[AWD-1:0], next_start_reg};

        unique case (state_reg)
            prat_pkg::ST_IDLE: begin
                if (s_accept) begin
                    res_load = 1'b1;
                    unique case (s_op)
                        prat_pkg::OP_APPEND: begin
                            if (count_reg == CW'(MAX_PAGES)) begin
                                res.status = prat_pkg::STAT_FULL;
                            end else if (s_page_size_bytes > prat_pkg::SIZE_LIMIT ||
                                         app_end[31]) begin
                                res.status = prat_pkg::STAT_OVERFLOW;
                            end else begin
                                ram_we          = 1'b1;
                                count_next      = CW'(count_reg + 1'b1);
                                // saturate when only the guard gap runs past the top
                                next_start_next = (app_nxt > {2'b0, prat_pkg::ADDR_MAX}) ?
                                                  prat_pkg::ADDR_MAX : app_nxt[AWD-1:0];
                                res.status      = prat_pkg::STAT_OK;
                                res.found_index = prat_pkg::INDEX_W'(count_reg);
                            end
                        end
                        prat_pkg::OP_ENCODE: begin
                            if (32'(s_page_index) >= 32'(count_reg)) begin
                                res.status = prat_pkg::STAT_BAD_INDEX;
                            end else if (s_byte_offset[1:0] != 2'b00) begin
                                res.status = prat_pkg::STAT_MISALIGNED;
                            end else begin
                                res_load   = 1'b0;
                                op_next    = prat_pkg::OP_ENCODE;
                                idx_next   = AW'(s_page_index);
                                woff_next  = s_byte_offset[29:2];
                                state_next = prat_pkg::ST_READ;
                            end
                        end
                        prat_pkg::OP_DECODE: begin
                            if (s_tagged_address[31] && count_reg != '0) begin
                                res_load        = 1'b0;
                                op_next         = prat_pkg::OP_DECODE;
                                addr_next       = s_tagged_address[AWD-1:0];
                                lo_next         = '0;
                                hi_next         = count_reg;
                                best_found_next = 1'b0;
                                state_next      = prat_pkg::ST_READ;
                            end
                        end
                        default: begin
                            res.status = prat_pkg::STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            prat_pkg::ST_READ: begin
                state_next = prat_pkg::ST_CHECK;
            end
            prat_pkg::ST_CHECK: begin
                if (op_reg == prat_pkg::OP_ENCODE) begin
                    if (out_free) begin
                        res_load   = 1'b1;
                        state_next = prat_pkg::ST_IDLE;
                        if (enc_addr[31]) begin
                            res.status = prat_pkg::STAT_OVERFLOW;
                        end else begin
                            res.status          = prat_pkg::STAT_OK;
                            res.encoded_address = {1'b1, enc_addr[30:0]};
                        end
                    end
                end else if (lo_c == hi_c) begin
                    // search window closed: last entry starting at or below the address
                    if (out_free) begin
                        res_load   = 1'b1;
                        state_next = prat_pkg::ST_IDLE;
                        if (bf_c && addr_reg < be_c) begin
                            res.status       = prat_pkg::STAT_OK;
                            res.found_index  = prat_pkg::INDEX_W'(bi_c);
                            res.found_offset = {dec_diff[27:0], 2'b00};
                        end
                    end
                end else begin
                    lo_next         = lo_c;
                    hi_next         = hi_c;
                    best_idx_next   = bi_c;
                    best_start_next = bs_c;
                    best_end_next   = be_c;
                    best_found_next = bf_c;
                    state_next      = prat_pkg::ST_READ;
                end
            end
            default: begin
                state_next = prat_pkg::ST_IDLE;
            end
        endcase

        if (res_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= prat_pkg::ST_IDLE;
            count_reg      <= '0;
            next_start_reg <= '0;
            m_valid_reg    <= 1'b0;
            op_reg         <= prat_pkg::OP_APPEND;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            next_start_reg <= next_start_next;
            m_valid_reg    <= m_valid_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        woff_reg       <= woff_next;
        idx_reg        <= idx_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        best_end_reg   <= best_end_next;
        best_found_reg <= best_found_next;
        if (res_load) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_res_reg.found_offset, m_res_reg.found_index,
                       m_res_reg.encoded_address, m_res_reg.status};

    // the page count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_PAGES))
        else $error("page count beyond table depth");

    // a running search keeps a nonempty window inside the filled table
    a_search_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != prat_pkg::ST_IDLE && op_reg == prat_pkg::OP_DECODE) |->
        (lo_reg < hi_reg && hi_reg <= count_reg))
        else $error("decode search window invalid");

    // a new request is never taken while an undelivered result would be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (!m_valid_reg || m_tready))
        else $error("request accepted over pending result");

    // the table only grows on an accepted append
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
        ($past(s_accept) && $past(s_op) == prat_pkg::OP_APPEND &&
         count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("page count changed without append");

endmodule
